// ----- rtl/core/hcfp_pkg.sv -----
// Shared types and constants for the hex command frame parser.
package hcfp_pkg;

	// Framing characters.
	localparam logic [7:0] CH_RESET = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;

	// Offsets that turn an ASCII hex digit into its value.
	localparam logic [7:0] HEX_OFS_DIGIT = 8'd48;
	localparam logic [7:0] HEX_OFS_UPPER = 8'd55;
	localparam logic [7:0] HEX_OFS_LOWER = 8'd87;

	// Frame layout: two code characters, four position digits, four speed digits.
	localparam int unsigned IDX_W      = 4;
	localparam logic [IDX_W-1:0] IDX_CODE_FIRST  = 4'd0;
	localparam logic [IDX_W-1:0] IDX_CODE_SECOND = 4'd1;
	localparam logic [IDX_W-1:0] IDX_SPEED_FIRST = 4'd6;
	localparam logic [IDX_W-1:0] FRAME_LEN       = 4'd10;

	// Result codes.
	typedef enum logic [2:0] {
		EV_RESET_ACK     = 3'd0,
		EV_SET_TENSION   = 3'd1,
		EV_SET_PICK      = 3'd2,
		EV_QUERY_TENSION = 3'd3,
		EV_QUERY_PICK    = 3'd4,
		EV_QUERY_MIC     = 3'd5,
		EV_UNRECOGNIZED  = 3'd6
	} event_t;

	// Class of a received character.
	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_RESET,
		KIND_END
	} char_kind_t;

	// One classified character as it travels from front to back.
	typedef struct packed {
		char_kind_t  kind;
		logic        is_hex;
		logic [3:0]  digit;
		logic [7:0]  ch;
	} hcfp_item_t;

endpackage

// ----- rtl/core/hex_command_frame_parser.sv -----
// Top level of the hex command frame parser.
// Takes one received character per cycle and answers '$' with a reset acknowledgement and
// '#' with the decoded command and the position and speed gathered from the frame; other
// characters give no result. A request passes a classifying register, a two-entry queue and
// the frame state with its result register, in that order. One character can be accepted every
// cycle; the only stall comes from a result waiting on out_ready, which backs up through
// the queue.
module hex_command_frame_parser import hcfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [15:0] position_value,
	output logic [15:0] speed_value
);

	logic       front_valid;
	logic       front_ready;
	hcfp_item_t front_item;
	logic       back_valid;
	logic       back_ready;
	hcfp_item_t back_item;

	// Classifying front end.
	hcfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	// Decoupling queue.
	hcfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// Frame state and result register.
	hcfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (back_valid),
		.item_ready     (back_ready),
		.item           (back_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_res      (event_res),
		.position_value (position_value),
		.speed_value    (speed_value)
	);

`ifndef SYNTHESIS
	// A reset acknowledgement always reports zero values.
	a_reset_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_RESET_ACK) |-> (position_value == '0 && speed_value == '0))
		else $error("reset acknowledgement with non-zero values");

	// A classified request held back by a full queue stays put.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && !front_ready) |=> (front_valid && $stable(front_item)))
		else $error("front stage lost or changed a stalled request");

	// The input only stalls while the front stage holds a request.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> front_valid)
		else $error("input stalled with an empty front stage");
`endif

endmodule

// ----- rtl/core/hcfp_front.sv -----
// Front end: accepts received characters and classifies them into one register stage.
module hcfp_front import hcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       item_valid,
	input  logic       item_ready,
	output hcfp_item_t item
);

	hcfp_item_t cls;
	logic       valid_s1;
	hcfp_item_t item_s1;
	logic [7:0] diff;

	// Classify the character and work out its hex value where it has one.
	always_comb begin
		cls.ch     = rx_byte;
		cls.is_hex = 1'b1;
		diff       = rx_byte - HEX_OFS_DIGIT;
		if (rx_byte inside {[8'h30:8'h39]}) begin
			diff = rx_byte - HEX_OFS_DIGIT;
		end else if (rx_byte inside {[8'h41:8'h46]}) begin
			diff = rx_byte - HEX_OFS_UPPER;
		end else if (rx_byte inside {[8'h61:8'h66]}) begin
			diff = rx_byte - HEX_OFS_LOWER;
		end else begin
			cls.is_hex = 1'b0;
		end
		cls.digit = diff[3:0];
		if (rx_byte == CH_RESET) begin
			cls.kind = KIND_RESET;
		end else if (rx_byte == CH_END) begin
			cls.kind = KIND_END;
		end else begin
			cls.kind = KIND_PLAIN;
		end
	end

	// The stage takes a new request whenever it is empty or its content moves on.
	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- rtl/core/hcfp_queue.sv -----
// Two-entry queue between the classifying front end and the frame back end.
module hcfp_queue import hcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  hcfp_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output hcfp_item_t pop_item
);

	hcfp_item_t mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/core/hcfp_back.sv -----
// Back end: holds the frame state, decodes commands and registers the results.
module hcfp_back import hcfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  hcfp_item_t  item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [15:0] position_value,
	output logic [15:0] speed_value
);

	logic [IDX_W-1:0] char_index_q;
	logic [7:0]       code_first_q;
	logic [7:0]       code_second_q;
	logic [15:0]      position_acc_q;
	logic [15:0]      speed_acc_q;
	logic             out_valid_q;
	event_t           event_q;
	logic [15:0]      position_q;
	logic [15:0]      speed_q;
	logic             take;
	logic             emits;
	event_t           decoded;

	// A request is taken whenever the result register is free or draining.
	assign item_ready = !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;
	assign emits      = (item.kind == KIND_RESET) || (item.kind == KIND_END);

	// Command decode from the two code characters.
	always_comb begin
		decoded = EV_UNRECOGNIZED;
		case (code_first_q)
			CH_ZERO: begin
				case (code_second_q)
					CH_ZERO: decoded = EV_SET_TENSION;
					CH_ONE:  decoded = EV_SET_PICK;
					default: decoded = EV_UNRECOGNIZED;
				endcase
			end
			CH_ONE: begin
				case (code_second_q)
					CH_ZERO: decoded = EV_QUERY_TENSION;
					CH_ONE:  decoded = EV_QUERY_PICK;
					CH_TWO:  decoded = EV_QUERY_MIC;
					default: decoded = EV_UNRECOGNIZED;
				endcase
			end
			default: decoded = EV_UNRECOGNIZED;
		endcase
	end

	// Frame state update; both framing characters clear the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q   <= '0;
			code_first_q   <= '0;
			code_second_q  <= '0;
			position_acc_q <= '0;
			speed_acc_q    <= '0;
		end else if (take) begin
			if (emits) begin
				char_index_q   <= '0;
				code_first_q   <= '0;
				code_second_q  <= '0;
				position_acc_q <= '0;
				speed_acc_q    <= '0;
			end else if (char_index_q < FRAME_LEN) begin
				if (char_index_q == IDX_CODE_FIRST) begin
					code_first_q <= item.ch;
				end else if (char_index_q == IDX_CODE_SECOND) begin
					code_second_q <= item.ch;
				end else if (char_index_q < IDX_SPEED_FIRST) begin
					if (item.is_hex) begin
						position_acc_q <= {position_acc_q[11:0], item.digit};
					end
				end else if (item.is_hex) begin
					speed_acc_q <= {speed_acc_q[11:0], item.digit};
				end
				char_index_q <= char_index_q + 4'd1;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emits;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; a reset acknowledgement carries zero values.
	always_ff @(posedge clk) begin
		if (take && emits) begin
			if (item.kind == KIND_RESET) begin
				event_q    <= EV_RESET_ACK;
				position_q <= '0;
				speed_q    <= '0;
			end else begin
				event_q    <= decoded;
				position_q <= position_acc_q;
				speed_q    <= speed_acc_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = event_q;
	assign position_value = position_q;
	assign speed_value    = speed_q;

endmodule
